// ===== hdl/kss_pkg.sv =====
// Shared types, codes and default sizes for the shared-store stack unit.
`default_nettype none
package kss_pkg;

   localparam int CAPACITY_DEFAULT   = 16;
   localparam int NUM_STACKS_DEFAULT = 8;
   localparam int DATA_WIDTH_DEFAULT = 32;

   typedef enum logic {
      FUNC_PUSH = 1'b0,
      FUNC_POP  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SLOT,
      S_WRITE
   } state_type;

   typedef struct packed {
      func_type           func;
      logic [2:0]         stack_index;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] pop_value;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic slot_read;
      logic commit;
   } ctrl_cmd_type;

endpackage
`default_nettype wire

// ===== hdl/kss_ctrl.sv =====
// Sequencing state machine for the shared-store stack unit.
`default_nettype none
module kss_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output kss_pkg::ctrl_cmd_type      cmd
);

   kss_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               can_commit;

   assign can_commit = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kss_pkg::S_IDLE: begin
            if (req_valid) state_in = kss_pkg::S_SLOT;
         end
         kss_pkg::S_SLOT: begin
            state_in = kss_pkg::S_WRITE;
         end
         kss_pkg::S_WRITE: begin
            if (can_commit) state_in = kss_pkg::S_IDLE;
         end
         default: begin
            state_in = kss_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.accept    = (state_ff == kss_pkg::S_IDLE) && req_valid;
      cmd.slot_read = (state_ff == kss_pkg::S_SLOT);
      cmd.commit    = (state_ff == kss_pkg::S_WRITE) && can_commit;
      req_stall     = (state_ff != kss_pkg::S_IDLE);
      rsp_valid_in  = cmd.commit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kss_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_to_slot : assert property (@(posedge clock) disable iff (reset)
      (!reset && cmd.accept) |=> (state_ff == kss_pkg::S_SLOT))
      else $error("accepted transaction did not move to slot read");

   a_rsp_from_write : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == kss_pkg::S_WRITE))
      else $error("response raised outside write-back");

   a_write_waits : assert property (@(posedge clock) disable iff (reset)
      (!reset && state_ff == kss_pkg::S_WRITE && rsp_valid_ff && rsp_stall)
      |=> (state_ff == kss_pkg::S_WRITE))
      else $error("write-back left while the output register was full");

endmodule
`default_nettype wire

// ===== hdl/kss_dpath.sv =====
// Datapath of the shared-store stack unit: data, link and top memories and the free list.
`default_nettype none
module kss_dpath #(
   parameter int CAPACITY   = kss_pkg::CAPACITY_DEFAULT,
   parameter int NUM_STACKS = kss_pkg::NUM_STACKS_DEFAULT,
   parameter int DATA_WIDTH = kss_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire kss_pkg::ctrl_cmd_type cmd,
   input  wire kss_pkg::req_type      req_payload,
   output kss_pkg::rsp_type           rsp_payload
);

   localparam int LINK_W = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int SW     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int IW     = (SW > 3) ? SW : 3;
   localparam int VW     = 64;
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

   logic [DATA_WIDTH-1:0] data_mem [CAPACITY];
   logic [LINK_W-1:0]     link_mem [CAPACITY];
   logic [LINK_W-1:0]     top_mem  [NUM_STACKS];

   logic [NUM_STACKS-1:0] top_valid_ff, top_valid_in;
   logic [LINK_W-1:0]     free_head_ff, free_head_in;
   logic [LINK_W-1:0]     fill_ff, fill_in;

   kss_pkg::req_type      req_ff;
   logic                  in_range_ff;
   logic [LINK_W-1:0]     top_rd_ff;
   logic                  top_ok_ff;
   logic [LINK_W-1:0]     slot_ff;
   logic                  ok_ff;
   logic                  implicit_ff;
   logic [LINK_W-1:0]     link_rd_ff;
   logic [DATA_WIDTH-1:0] data_rd_ff;
   kss_pkg::rsp_type      rsp_ff;

   logic [IW-1:0]         req_idx_wide, cur_idx_wide;
   logic [SW-1:0]         req_addr, cur_addr;
   logic                  req_in_range;
   logic                  is_push;
   logic [LINK_W-1:0]     slot;
   logic                  slot_ok;
   logic [ADDR_W-1:0]     slot_addr, slot_ff_addr;
   logic [LINK_W-1:0]     next_link;
   logic                  push_commit, pop_commit;
   logic [LINK_W-1:0]     top_wdata, link_wdata;
   logic [VW-1:0]         push_wide, rd_wide;

   always_comb begin
      req_idx_wide = IW'(req_payload.stack_index);
      req_addr     = req_idx_wide[SW-1:0];
      req_in_range = 32'(req_payload.stack_index) < NUM_STACKS;
      cur_idx_wide = IW'(req_ff.stack_index);
      cur_addr     = cur_idx_wide[SW-1:0];
      is_push      = (req_ff.func == kss_pkg::FUNC_PUSH);
      slot         = is_push ? free_head_ff : top_rd_ff;
      slot_ok      = is_push ? (in_range_ff && (free_head_ff < NULL_LINK)) : top_ok_ff;
      slot_addr    = slot[ADDR_W-1:0];
      slot_ff_addr = slot_ff[ADDR_W-1:0];
      // Slots at or beyond the fill count were never written and still link to the next one.
      next_link    = implicit_ff ? (slot_ff + LINK_W'(1)) : link_rd_ff;
      push_commit  = cmd.commit && ok_ff && is_push;
      pop_commit   = cmd.commit && ok_ff && !is_push;
      top_wdata    = is_push ? slot_ff : next_link;
      link_wdata   = is_push ? (top_ok_ff ? top_rd_ff : NULL_LINK) : free_head_ff;
      push_wide    = VW'($unsigned(req_ff.push_value));
      rd_wide      = VW'(data_rd_ff);
   end

   always_comb begin
      top_valid_in = top_valid_ff;
      free_head_in = free_head_ff;
      fill_in      = fill_ff;
      if (push_commit) begin
         top_valid_in[cur_addr] = 1'b1;
         free_head_in           = next_link;
         if (implicit_ff) fill_in = fill_ff + LINK_W'(1);
      end else if (pop_commit) begin
         top_valid_in[cur_addr] = (next_link < NULL_LINK);
         free_head_in           = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_valid_ff <= '0;
         free_head_ff <= '0;
         fill_ff      <= '0;
      end else begin
         top_valid_ff <= top_valid_in;
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) top_rd_ff <= top_mem[req_addr];
      if (push_commit || pop_commit) top_mem[cur_addr] <= top_wdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.slot_read) link_rd_ff <= link_mem[slot_addr];
      if (push_commit || pop_commit) link_mem[slot_ff_addr] <= link_wdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.slot_read) data_rd_ff <= data_mem[slot_addr];
      if (push_commit) data_mem[slot_ff_addr] <= push_wide[DATA_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff      <= req_payload;
         in_range_ff <= req_in_range;
         top_ok_ff   <= req_in_range && top_valid_ff[req_addr];
      end
      if (cmd.slot_read) begin
         slot_ff     <= slot;
         ok_ff       <= slot_ok;
         implicit_ff <= (slot >= fill_ff);
      end
      if (cmd.commit) begin
         if (ok_ff) begin
            rsp_ff.status <= kss_pkg::STATUS_DONE;
         end else if (is_push) begin
            rsp_ff.status <= kss_pkg::STATUS_FULL;
         end else begin
            rsp_ff.status <= kss_pkg::STATUS_EMPTY;
         end
         rsp_ff.pop_value <= pop_commit ? rd_wide[31:0] : '0;
      end
   end

   assign rsp_payload = rsp_ff;

   a_head_within_fill : assert property (@(posedge clock) disable iff (reset)
      free_head_ff <= fill_ff)
      else $error("free list head lies beyond the fill count");

   a_fill_only_on_push : assert property (@(posedge clock) disable iff (reset)
      (!reset && !(push_commit && implicit_ff)) |=> $stable(fill_ff))
      else $error("fill count moved without a push to a fresh slot");

   a_pop_frees_slot : assert property (@(posedge clock) disable iff (reset)
      (!reset && pop_commit) |=> (free_head_ff == $past(slot_ff)))
      else $error("popped slot did not become the free list head");

endmodule
`default_nettype wire

// ===== hdl/k_stacks_shared_store_unit.sv =====
// Top level of the shared-store stack unit: several stacks linked through one data store.
// A transaction passes the top-slot read, the link and data read and the write-back into the
// output register; write-back waits only while rsp_stall holds the previous result there.
// No new transaction is accepted until the previous one has finished its write-back; each
// of these steps goes through a single-port synchronous memory.
// Reset is synchronous and takes effect at once; a fill count stands in for the link
// initialization, so there is no clearing pass.
`default_nettype none
module k_stacks_shared_store_unit #(
   parameter int CAPACITY   = kss_pkg::CAPACITY_DEFAULT,
   parameter int NUM_STACKS = kss_pkg::NUM_STACKS_DEFAULT,
   parameter int DATA_WIDTH = kss_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire kss_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output kss_pkg::rsp_type      rsp_payload
);

   kss_pkg::ctrl_cmd_type cmd;

   kss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   kss_dpath #(
      .CAPACITY   (CAPACITY),
      .NUM_STACKS (NUM_STACKS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire
